/* rtl/core/mvam_pkg.sv */
// mvam_pkg: shared constants, codes and request/result types of the voice mixer
// no dependencies; imported by multi_voice_audio_mixer
`default_nettype none

package mvam_pkg;

  // voice table and sample memory geometry
  localparam int VOICES       = 16;
  localparam int VIDX_W       = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SAMPLE_WORDS = 4096;
  localparam int SADDR_W      = $clog2(SAMPLE_WORDS);

  // field widths
  localparam int FIELD_ADDR_W = 12;
  localparam int SAMPLE_W     = 16;
  localparam int GAIN_W       = 9;
  localparam int FRAMES_W     = 12;
  localparam int INDEX_W      = 4;

  // q8 arithmetic widths
  localparam int Q8_SHIFT = 8;
  localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int TERM_W   = PROD_W - Q8_SHIFT;
  localparam int ACC_W    = TERM_W + VIDX_W + 1;
  localparam int MPROD_W  = ACC_W + GAIN_W + 1;

  localparam logic [GAIN_W-1:0] MASTER_UNITY = GAIN_W'(256);

  // request kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_PLAY  = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic [FIELD_ADDR_W-1:0]   address;
    logic signed [SAMPLE_W-1:0] sample;
    logic [FRAMES_W-1:0]       frame_count;
    logic                      loop_flag;
    logic [GAIN_W-1:0]         volume;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       status;
    logic [INDEX_W-1:0]         voice_index;
  } out_t;

  // one entry of the voice table
  typedef struct packed {
    logic                loops;
    logic [GAIN_W-1:0]   gain;
    logic [SADDR_W-1:0]  start;
    logic [FRAMES_W-1:0] length;
    logic [SADDR_W-1:0]  position;
    logic [FRAMES_W-1:0] frames_left;
  } voice_t;

endpackage

`default_nettype wire

/* rtl/core/multi_voice_audio_mixer.sv */
// multi_voice_audio_mixer: stereo pcm mixer, sample memory plus voice table walked per frame
// depends on mvam_pkg
//
//   channel | direction | payload  | meaning
//   in      | input     | in_t     | sample write, voice start or frame request
//   out     | output    | out_t    | one result per request
//   cfg     | input     | 9 bits   | master volume, q8
//
// sample write, voice start and unused kind each answer in the next cycle
// a frame walks the playing voices in turn, then flushes, scales by master volume and saturates;
//   each playing voice costs a voice table read, a sample memory read and a multiply
// reset clears the controller, the active vector and master volume;
//   sample memory and voice table are not cleared, a table entry is read only after a start
// in_ready drops while a frame is mixed and while an untaken result holds the output register
`default_nettype none

module multi_voice_audio_mixer
  import mvam_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [GAIN_W-1:0] cfg_data
);

  // controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_VREAD  = 3'd1;  // voice table read issued
  localparam logic [2:0] S_SREAD  = 3'd2;  // voice entry back, sample reads issued, entry updated
  localparam logic [2:0] S_MUL    = 3'd3;  // samples back, times voice gain
  localparam logic [2:0] S_FLUSH  = 3'd4;  // last product enters the sums
  localparam logic [2:0] S_MSCALE = 3'd5;  // sums times master volume
  localparam logic [2:0] S_SAT    = 3'd6;  // round toward zero, clamp, load result

  localparam logic signed [PROD_W-1:0]  PROD_BIAS = PROD_W'(255);
  localparam logic signed [MPROD_W-1:0] MPROD_BIAS = MPROD_W'(255);
  localparam logic signed [MPROD_W-1:0] SAT_MAX = MPROD_W'(32767);
  localparam logic signed [MPROD_W-1:0] SAT_MIN = -MPROD_W'(32768);

  // storage
  logic signed [SAMPLE_W-1:0] smem [SAMPLE_WORDS];
  voice_t                     vmem [VOICES];

  // registers
  logic [2:0]                 state;
  logic [VOICES-1:0]          voice_active;
  logic [GAIN_W-1:0]          master_volume;
  logic [VIDX_W-1:0]          vidx;
  logic                       prod_valid;
  logic signed [PROD_W-1:0]   prod_l, prod_r;
  logic signed [ACC_W-1:0]    acc_l, acc_r;
  logic signed [MPROD_W-1:0]  mprod_l, mprod_r;
  logic signed [SAMPLE_W-1:0] sm_rd_l, sm_rd_r;
  voice_t                     vm_rd;

  // memory access controls
  logic                sm_we;
  logic                sm_re;
  logic [SADDR_W-1:0]  sm_waddr;
  logic [SADDR_W-1:0]  sm_ra_l, sm_ra_r;
  logic                vm_we;
  logic                vm_re;
  logic [VIDX_W-1:0]   vm_waddr;
  voice_t              vm_wdata;

  // combinational helpers
  logic                accept;
  logic                out_free;
  logic [SADDR_W-1:0]  req_addr;
  logic                free_found;
  logic [VIDX_W-1:0]   free_idx;
  logic                first_found;
  logic [VIDX_W-1:0]   first_idx;
  logic                next_found;
  logic [VIDX_W-1:0]   next_idx;
  logic [VOICES-1:0]   above_mask;
  logic [FRAMES_W-1:0] fl_dec;
  logic                keep_active;
  voice_t              v_upd;
  out_t                res_simple;
  out_t                res_frame;
  logic [VIDX_W+INDEX_W-1:0] free_ext;

  // lowest set bit of a voice vector
  function automatic logic [VIDX_W:0] lowest_set(input logic [VOICES-1:0] vec);
    logic [VIDX_W:0] res;
    res = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res = {1'b1, VIDX_W'(i)};
      end
    end
    return res;
  endfunction

  // per voice q8 product divided by 256, toward zero
  function automatic logic signed [TERM_W-1:0] q8_term(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] b;
    b = p + (p[PROD_W-1] ? PROD_BIAS : '0);
    return TERM_W'(b >>> Q8_SHIFT);
  endfunction

  // master scaled sum divided by 256 toward zero, then clamped to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] q8_sat(input logic signed [MPROD_W-1:0] p);
    logic signed [MPROD_W-1:0] b;
    logic signed [MPROD_W-1:0] q;
    b = p + (p[MPROD_W-1] ? MPROD_BIAS : '0);
    q = b >>> Q8_SHIFT;
    if (q > SAT_MAX) begin
      return SAMPLE_W'(SAT_MAX);
    end else if (q < SAT_MIN) begin
      return SAMPLE_W'(SAT_MIN);
    end
    return SAMPLE_W'(q);
  endfunction

  // address field taken modulo the memory size
  function automatic logic [SADDR_W-1:0] to_saddr(input logic [FIELD_ADDR_W-1:0] a);
    logic [SADDR_W+FIELD_ADDR_W-1:0] w;
    w = (SADDR_W + FIELD_ADDR_W)'(a);
    return w[SADDR_W-1:0];
  endfunction

  // handshake
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign req_addr  = to_saddr(in_data.address);

  // voice searches: free slot for a start, first and next playing voice for a frame
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      above_mask[i] = VIDX_W'(i) > vidx;
    end
    {free_found, free_idx}   = lowest_set(~voice_active);
    {first_found, first_idx} = lowest_set(voice_active);
    {next_found, next_idx}   = lowest_set(voice_active & above_mask);
  end

  // advance the voice whose entry just came back from the table
  always_comb begin
    fl_dec      = (vm_rd.frames_left != '0) ? vm_rd.frames_left - FRAMES_W'(1)
                                            : vm_rd.frames_left;
    v_upd       = vm_rd;
    keep_active = 1'b1;
    v_upd.position    = vm_rd.position + SADDR_W'(2);
    v_upd.frames_left = fl_dec;
    if (fl_dec == '0) begin
      if (vm_rd.loops && vm_rd.length != '0) begin
        // looped sound wraps back to its start
        v_upd.position    = vm_rd.start;
        v_upd.frames_left = vm_rd.length;
      end else begin
        keep_active = 1'b0;
      end
    end
  end

  // memory port controls
  always_comb begin
    sm_we    = 1'b0;
    sm_waddr = req_addr;
    sm_re    = 1'b0;
    sm_ra_l  = vm_rd.position;
    sm_ra_r  = vm_rd.position + SADDR_W'(1);
    vm_we    = 1'b0;
    vm_re    = 1'b0;
    vm_waddr = vidx;
    vm_wdata = v_upd;
    unique case (state)
      S_IDLE: begin
        if (accept && in_data.kind == KIND_WRITE) begin
          sm_we = 1'b1;
        end
        if (accept && in_data.kind == KIND_PLAY && free_found) begin
          vm_we    = 1'b1;
          vm_waddr = free_idx;
          vm_wdata = '{loops: in_data.loop_flag, gain: in_data.volume, start: req_addr,
                       length: in_data.frame_count, position: req_addr,
                       frames_left: in_data.frame_count};
        end
      end
      S_VREAD: begin
        vm_re = 1'b1;
      end
      S_SREAD: begin
        sm_re = 1'b1;
        vm_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // results
  always_comb begin
    free_ext   = (VIDX_W + INDEX_W)'(free_idx);
    res_simple = '0;
    if (in_data.kind == KIND_PLAY) begin
      res_simple.status      = !free_found;
      res_simple.voice_index = free_found ? free_ext[INDEX_W-1:0] : '0;
    end
    res_frame              = '0;
    res_frame.left_sample  = q8_sat(mprod_l);
    res_frame.right_sample = q8_sat(mprod_r);
  end

  // sample memory, one write port and two registered read ports
  always_ff @(posedge clk) begin
    if (sm_we) begin
      smem[sm_waddr] <= in_data.sample;
    end
    if (sm_re) begin
      sm_rd_l <= smem[sm_ra_l];
      sm_rd_r <= smem[sm_ra_r];
    end
  end

  // voice table, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vm_waddr] <= vm_wdata;
    end
    if (vm_re) begin
      vm_rd <= vmem[vidx];
    end
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      voice_active  <= '0;
      master_volume <= MASTER_UNITY;
      prod_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        master_volume <= cfg_data;
      end
      // a new result loads the output register, else a taken one empties it
      if ((state == S_IDLE && accept && in_data.kind != KIND_FRAME) || state == S_SAT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      prod_valid <= (state == S_MUL);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.kind == KIND_FRAME) begin
              state <= first_found ? S_VREAD : S_FLUSH;
            end else if (in_data.kind == KIND_PLAY && free_found) begin
              // a zero length start still reports its voice but leaves it idle
              voice_active[free_idx] <= (in_data.frame_count != '0);
            end
          end
        end
        S_VREAD: state <= S_SREAD;
        S_SREAD: begin
          voice_active[vidx] <= keep_active;
          state              <= S_MUL;
        end
        S_MUL: state <= next_found ? S_VREAD : S_FLUSH;
        S_FLUSH: state <= S_MSCALE;
        S_MSCALE: state <= S_SAT;
        S_SAT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      out_data <= res_simple;
      acc_l    <= '0;
      acc_r    <= '0;
      vidx     <= first_idx;
    end else if (prod_valid) begin
      acc_l <= acc_l + ACC_W'(q8_term(prod_l));
      acc_r <= acc_r + ACC_W'(q8_term(prod_r));
    end
    if (state == S_MUL) begin
      prod_l <= PROD_W'(sm_rd_l) * PROD_W'($signed({1'b0, vm_rd.gain}));
      prod_r <= PROD_W'(sm_rd_r) * PROD_W'($signed({1'b0, vm_rd.gain}));
      vidx   <= next_idx;
    end
    if (state == S_MSCALE) begin
      mprod_l <= MPROD_W'(acc_l) * MPROD_W'($signed({1'b0, master_volume}));
      mprod_r <= MPROD_W'(acc_r) * MPROD_W'($signed({1'b0, master_volume}));
    end
    if (state == S_SAT) begin
      out_data <= res_frame;
    end
  end

`ifndef NO_ASSERTIONS
  // requests other than frames answer in the next cycle
  a_simple_result: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.kind != KIND_FRAME) |=> out_valid)
    else $error("non frame request gave no result");

  // a start with every voice busy is rejected
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.kind == KIND_PLAY && (&voice_active))
      |=> (out_valid && out_data.status == 1'b1 && out_data.voice_index == '0))
    else $error("start with no free voice not rejected");

  // a start of nonzero length adds exactly one playing voice
  a_start_adds: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.kind == KIND_PLAY && free_found && in_data.frame_count != '0)
      |=> ($countones(voice_active) == $past($countones(voice_active)) + 1))
    else $error("start did not add one voice");

  // the output register is empty when a frame result is loaded
  a_frame_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_SAT) |-> !out_valid)
    else $error("frame result would overwrite a pending result");
`endif

endmodule

`default_nettype wire
